### rtl/lmv_pkg.sv
// Shared constants, codes and inter-module types for the label mode vote unit.
package lmv_pkg;

  localparam int GRID_U     = 256;
  localparam int GRID_V     = 128;
  localparam int SLOTS      = 32;
  localparam int CELL_TOTAL = GRID_U * GRID_V;
  localparam int CELL_AW    = $clog2(CELL_TOTAL);
  localparam int CELL_CMP_W = ((CELL_AW > 15) ? CELL_AW : 15) + 1;
  localparam int SIW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W     = $clog2(SLOTS + 1);
  localparam int SLOT_AW    = CELL_AW + SIW;
  localparam int LABEL_W    = 24;
  localparam int COUNT_W    = 16;
  localparam int CFG_W      = 6;
  localparam int LIM_W      = ((CFG_W > FILL_W) ? CFG_W : FILL_W) + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   LIM_RESET = CFG_W'(25);

  localparam logic CMD_VOTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic               clear;
    logic               valid;
    logic [SIW-1:0]     idx;
    logic               vote;
    logic [LABEL_W-1:0] label;
  } scan_ctl_t;

  typedef struct packed {
    logic               match;
    logic [SIW-1:0]     match_idx;
    logic [COUNT_W-1:0] match_cnt;
    logic [LABEL_W-1:0] best_label;
    logic [COUNT_W-1:0] best_count;
  } scan_res_t;

endpackage

### rtl/per_cell_label_mode_vote_unit.sv
// Top level of the per-cell label mode vote unit: sequencer, stores and result port.
//
// A request (start high while busy is low) names a cell and either casts a vote for a
// label (cmd 0) or only reads the cell (cmd 1). Each cell holds up to SLOTS distinct
// labels with 16-bit saturating counts; a new label takes the next free slot while the
// fill is below slots_in_use (clamped to 1..SLOTS), otherwise the vote is dropped with
// status 2. Every request yields exactly one result, shown for one cycle with done high:
// the cell's mode label and count (earliest slot wins ties), status 1 for an empty cell.
// The receiver cannot stall, so sample the result in the cycle done is high. A request
// keeps busy high through the fill count read, the slot scan and the write-back, and
// the result appears in the cycle busy falls; no new request is taken until then. The
// slot scan does one slot store read and one compare per cycle over the filled slots.
// A cell index outside the grid is answered as empty in the next cycle without going
// busy. After reset the block runs a clearing pass over the fill counts, one cell per
// cycle, with busy high; the slots_in_use register is written with cfg_wr and cfg_data
// and is applied when a request finishes, so write it only while no request is in flight.
module per_cell_label_mode_vote_unit import lmv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [14:0]        cell_req,
  input  logic [LABEL_W-1:0] label,
  output logic               done,
  output logic [LABEL_W-1:0] mode_label,
  output logic [COUNT_W-1:0] mode_count,
  output logic [1:0]         status,
  input  logic               cfg_wr,
  input  logic [CFG_W-1:0]   cfg_data
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FILL  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_UPD   = 5'b10000
  } state_t;

  state_t               state;
  logic [CELL_AW-1:0]   clr_addr;
  logic                 cmd_q;
  logic [CELL_AW-1:0]   cell_q;
  logic [LABEL_W-1:0]   label_q;
  logic [FILL_W-1:0]    fill_q;
  logic [FILL_W-1:0]    rd_idx;
  logic                 pend;
  logic [SIW-1:0]       pend_idx;
  logic [CFG_W-1:0]     slots_in_use;

  logic                 accept;
  logic                 in_range;
  logic                 issue;
  logic                 vote;
  logic [LIM_W-1:0]     lim;
  logic                 room;
  logic                 upd_new;
  logic                 upd_match;
  logic                 upd_drop;

  logic                 fill_we;
  logic [CELL_AW-1:0]   fill_waddr;
  logic [FILL_W-1:0]    fill_wdata;
  logic [FILL_W-1:0]    fill_rdata;

  logic                         slot_we;
  logic [SLOT_AW-1:0]           slot_waddr;
  logic [LABEL_W+COUNT_W-1:0]   slot_wdata;
  logic [LABEL_W+COUNT_W-1:0]   slot_rdata;

  scan_ctl_t            sctl;
  scan_res_t            sres;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = CELL_CMP_W'(cell_req) < CELL_CMP_W'(CELL_TOTAL);
  assign vote     = (cmd_q == CMD_VOTE);

  // Issue one slot read per cycle until every filled slot has gone out.
  assign issue = (state == S_SCAN) && (rd_idx < fill_q);

  // Effective slot limit: zero acts as one, anything above SLOTS as SLOTS.
  always_comb begin
    lim = LIM_W'(slots_in_use);
    if (slots_in_use == '0) begin
      lim = LIM_W'(1);
    end else if (LIM_W'(slots_in_use) > LIM_W'(SLOTS)) begin
      lim = LIM_W'(SLOTS);
    end
  end

  assign room      = LIM_W'(fill_q) < lim;
  assign upd_match = (state == S_UPD) && vote && sres.match;
  assign upd_new   = (state == S_UPD) && vote && !sres.match && room;
  assign upd_drop  = (state == S_UPD) && vote && !sres.match && !room;

  // Fill count store: zeroed by the clearing pass, bumped when a slot is taken.
  assign fill_we    = (state == S_CLEAR) || upd_new;
  assign fill_waddr = (state == S_CLEAR) ? clr_addr : cell_q;
  assign fill_wdata = (state == S_CLEAR) ? '0 : (fill_q + FILL_W'(1));

  lmv_ram #(
    .WIDTH (FILL_W),
    .AW    (CELL_AW)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (CELL_AW'(cell_req)),
    .rdata (fill_rdata)
  );

  // Slot store: write back the bumped count, or place a new label with count one.
  assign slot_we    = upd_match || upd_new;
  assign slot_waddr = {cell_q, (upd_match ? sres.match_idx : fill_q[SIW-1:0])};
  assign slot_wdata = {label_q, (upd_match ? sres.match_cnt : COUNT_W'(1))};

  lmv_ram #(
    .WIDTH (LABEL_W + COUNT_W),
    .AW    (SLOT_AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr ({cell_q, rd_idx[SIW-1:0]}),
    .rdata (slot_rdata)
  );

  assign sctl.clear = (state == S_FILL);
  assign sctl.valid = pend;
  assign sctl.idx   = pend_idx;
  assign sctl.vote  = vote;
  assign sctl.label = label_q;

  lmv_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (sctl),
    .slot_label (slot_rdata[LABEL_W+COUNT_W-1:COUNT_W]),
    .slot_count (slot_rdata[COUNT_W-1:0]),
    .res        (sres)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= LIM_RESET;
    end else if (cfg_wr) begin
      slots_in_use <= cfg_data;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= issue;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + CELL_AW'(1);
          if (clr_addr == CELL_AW'(CELL_TOTAL - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_range) begin
              state <= S_FILL;
            end else begin
              // Outside the grid: answer as an empty cell, touch nothing.
              done <= 1'b1;
            end
          end
        end
        S_FILL: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          // The last slot in flight is folded in at this same edge.
          if (!issue) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request fields, scan counters and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      cell_q  <= CELL_AW'(cell_req);
      label_q <= label;
      if (!in_range) begin
        mode_label <= '0;
        mode_count <= '0;
        status     <= ST_EMPTY;
      end
    end
    if (state == S_FILL) begin
      fill_q <= (fill_rdata > FILL_W'(SLOTS)) ? FILL_W'(SLOTS) : fill_rdata;
      rd_idx <= '0;
    end
    if (issue) begin
      rd_idx   <= rd_idx + FILL_W'(1);
      pend_idx <= rd_idx[SIW-1:0];
    end
    if (state == S_UPD) begin
      if (fill_q == '0) begin
        if (vote) begin
          // First label of the cell is its mode.
          mode_label <= label_q;
          mode_count <= COUNT_W'(1);
          status     <= ST_OK;
        end else begin
          mode_label <= '0;
          mode_count <= '0;
          status     <= ST_EMPTY;
        end
      end else begin
        // A newly taken slot has count one and cannot beat an earlier slot.
        mode_label <= sres.best_label;
        mode_count <= sres.best_count;
        status     <= upd_drop ? ST_DROPPED : ST_OK;
      end
    end
  end

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_EMPTY) |-> (mode_count == '0) && (mode_label == '0))
    else $error("empty result with nonzero mode");

  a_held_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_EMPTY) |-> (mode_count != '0))
    else $error("mode count zero on a non-empty result");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_we && (state != S_CLEAR) |-> (LIM_W'(fill_wdata) <= lim))
    else $error("fill count written past the slot limit");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_idx <= fill_q))
    else $error("slot scan ran past the fill count");

  a_upd_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> done && (state == S_IDLE))
    else $error("update did not produce a result");
`endif

endmodule

### rtl/lmv_ram.sv
// Generic single-write, single-read memory with registered read data.
module lmv_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/lmv_scan.sv
// Per-slot compare unit: label match, saturating bump and running maximum.
module lmv_scan import lmv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  scan_ctl_t          ctl,
  input  logic [LABEL_W-1:0] slot_label,
  input  logic [COUNT_W-1:0] slot_count,
  output scan_res_t          res
);

  logic               have;
  logic               hit;
  logic [COUNT_W-1:0] eff;

  // Count as it stands after this vote: bump the matching slot, hold at max.
  always_comb begin
    hit = ctl.vote && (slot_label == ctl.label);
    eff = slot_count;
    if (hit && (slot_count != COUNT_MAX)) begin
      eff = slot_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      have      <= 1'b0;
      res.match <= 1'b0;
    end else if (ctl.valid) begin
      have <= 1'b1;
      if (hit) begin
        res.match     <= 1'b1;
        res.match_idx <= ctl.idx;
        res.match_cnt <= eff;
      end
      // Strictly greater: earliest slot keeps ties.
      if (!have || (eff > res.best_count)) begin
        res.best_label <= slot_label;
        res.best_count <= eff;
      end
    end
  end

endmodule

### sim/label_vote_checker.sv
// Checker for the label mode vote unit: watches requests and results, predicts, compares.
module label_vote_checker import lmv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cmd,
  input  logic [14:0]        cell_req,
  input  logic [LABEL_W-1:0] label,
  input  logic               done,
  input  logic [LABEL_W-1:0] mode_label,
  input  logic [COUNT_W-1:0] mode_count,
  input  logic [1:0]         status,
  input  logic               cfg_wr,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 fault_count,
  output int                 results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LABEL_W-1:0] lbl;
    logic [COUNT_W-1:0] cnt;
    status_t            st;
  } cell_mode_t;

  // Shadow copy of the per-cell label lists and the slot limit register.
  logic [LABEL_W-1:0] held_label [CELL_TOTAL*SLOTS];
  logic [COUNT_W-1:0] held_count [CELL_TOTAL*SLOTS];
  int unsigned        cell_fill  [CELL_TOTAL];
  logic [CFG_W-1:0]   slot_limit;

  cell_mode_t mode_q [$];
  int         result_idx;

  // Apply one request to the shadow lists and return the mode it must report.
  function automatic cell_mode_t tally_request(logic c, logic [14:0] cl,
                                               logic [LABEL_W-1:0] lb);
    cell_mode_t  ans;
    int          fill;
    int          base;
    int          hit;
    int          best;
    int          lim;
    status_t     st;
    ans = '{lbl: '0, cnt: '0, st: ST_EMPTY};
    if (int'(cl) >= CELL_TOTAL) return ans;
    st   = ST_OK;
    base = int'(cl) * SLOTS;
    fill = int'(cell_fill[cl]);
    lim  = int'(slot_limit);
    if (lim < 1) lim = 1;
    if (lim > SLOTS) lim = SLOTS;
    if (c == CMD_VOTE) begin
      hit = -1;
      for (int i = 0; i < fill; i++)
        if (hit < 0 && held_label[base+i] == lb) hit = i;
      if (hit >= 0) begin
        if (held_count[base+hit] != COUNT_MAX)
          held_count[base+hit] = held_count[base+hit] + COUNT_W'(1);
      end else if (fill < lim) begin
        held_label[base+fill] = lb;
        held_count[base+fill] = COUNT_W'(1);
        fill++;
        cell_fill[cl] = unsigned'(fill);
      end else begin
        st = ST_DROPPED;
      end
    end
    if (fill == 0) return ans;
    best = 0;
    for (int i = 1; i < fill; i++)
      if (held_count[base+i] > held_count[base+best]) best = i;
    ans.lbl = held_label[base+best];
    ans.cnt = held_count[base+best];
    ans.st  = st;
    return ans;
  endfunction

  always @(posedge clk) begin
    cell_mode_t want;
    if (rst) begin
      foreach (cell_fill[i]) cell_fill[i] = 0;
      slot_limit   = LIM_RESET;
      mode_q.delete();
      results_owed = 0;
      fault_count  = 0;
      result_idx   = 0;
    end else begin
      // Retire the result first; a request taken at this edge answers later.
      if (done === 1'b1) begin
        if (mode_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result %0d with no request waiting: label %h count %0d status %0d",
                     result_idx, mode_label, mode_count, status);
        end else begin
          want = mode_q.pop_front();
          results_owed--;
          if (mode_label !== want.lbl || mode_count !== want.cnt ||
              status !== want.st) begin
            fault_count++;
            if (fault_count <= 10)
              $display("result %0d differs: expected %h/%0d/%0d, got %h/%0d/%0d",
                       result_idx, want.lbl, want.cnt, want.st,
                       mode_label, mode_count, status);
          end
        end
        result_idx++;
      end
      if (cfg_wr === 1'b1) slot_limit = cfg_data;
      if (start === 1'b1 && busy === 1'b0) begin
        mode_q.push_back(tally_request(cmd, cell_req, label));
        results_owed++;
      end
    end
  end

endmodule

### sim/testbench.sv
// Top of the label mode vote testbench: clock, reset, request stimulus and verdict.
module testbench;
  import lmv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAST_CELL   = CELL_TOTAL - 1;
  localparam int HOT_CELLS   = 8;
  localparam int POOL_LABELS = 48;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 100;
  // Repeated votes for one label, enough to build a count well above the rest.
  localparam int BURST_VOTES = 20;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               start    = 1'b0;
  logic               cmd      = CMD_VOTE;
  logic [14:0]        cell_req = '0;
  logic [LABEL_W-1:0] label    = '0;
  logic               cfg_wr   = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               busy;
  logic               done;
  logic [LABEL_W-1:0] mode_label;
  logic [COUNT_W-1:0] mode_count;
  logic [1:0]         status;
  int                 fault_count;
  int                 results_owed;

  logic [14:0]        hot_cell   [HOT_CELLS];
  logic [LABEL_W-1:0] label_pool [POOL_LABELS];

  per_cell_label_mode_vote_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .cell_req   (cell_req),
    .label      (label),
    .done       (done),
    .mode_label (mode_label),
    .mode_count (mode_count),
    .status     (status),
    .cfg_wr     (cfg_wr),
    .cfg_data   (cfg_data)
  );

  label_vote_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .cell_req     (cell_req),
    .label        (label),
    .done         (done),
    .mode_label   (mode_label),
    .mode_count   (mode_count),
    .status       (status),
    .cfg_wr       (cfg_wr),
    .cfg_data     (cfg_data),
    .fault_count  (fault_count),
    .results_owed (results_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Safety net: the slowest legal run (clearing pass, long gaps on every
  // random request) is well under a tenth of this.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Pick the idle time after a request: mostly none or short, now and then
  // long enough to span a whole slot scan of a full cell.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  // Present one request and hold it until the block takes it. Busy only moves
  // at rising edges, so sample it at the falling edge. Enter and leave on a
  // rising edge; with no gap, start stays high for the next request.
  task automatic send_request(input logic c, input logic [14:0] cl,
                              input logic [LABEL_W-1:0] lb, input int gap);
    start    <= 1'b1;
    cmd      <= c;
    cell_req <= cl;
    label    <= lb;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every outstanding request has answered.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (results_owed != 0 || busy !== 1'b0);
    @(posedge clk);
  endtask

  // Write the slot limit only with the block idle and nothing owed.
  task automatic set_slot_limit(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_wr   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          r;
    int          lim;
    int          pick;
    bit          steady;
    logic [14:0] cl;

    foreach (label_pool[i]) label_pool[i] = LABEL_W'($urandom());
    foreach (hot_cell[i])   hot_cell[i]   = 15'($urandom_range(0, LAST_CELL));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Hold off through the clearing pass over the fill counters.
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);

    // ---- Directed part, slot limit at its reset value ----
    // Read an empty cell; the label is noise and must be ignored.
    send_request(CMD_READ, 15'd0, 24'hFFFFFF, pick_gap(1'b0));
    // Extreme labels in the first cell; a one-one tie goes to the earlier slot.
    send_request(CMD_VOTE, 15'd0, 24'h000000, pick_gap(1'b0));
    send_request(CMD_VOTE, 15'd0, 24'hFFFFFF, pick_gap(1'b0));
    send_request(CMD_VOTE, 15'd0, 24'hFFFFFF, pick_gap(1'b0));
    // Same at the last cell of the grid, with a read before and after.
    send_request(CMD_READ, 15'(LAST_CELL), 24'h5A5A5A, pick_gap(1'b0));
    send_request(CMD_VOTE, 15'(LAST_CELL), 24'hFFFFFF, pick_gap(1'b0));
    send_request(CMD_VOTE, 15'(LAST_CELL), 24'h000000, pick_gap(1'b0));
    send_request(CMD_READ, 15'(LAST_CELL), 24'h000000, pick_gap(1'b0));

    // A limit of zero acts as one: second label in a cell is dropped.
    set_slot_limit('0);
    send_request(CMD_VOTE, 15'd1, 24'h123456, pick_gap(1'b0));
    send_request(CMD_VOTE, 15'd1, 24'hABCDEF, pick_gap(1'b0));
    send_request(CMD_VOTE, 15'd1, 24'h123456, pick_gap(1'b0));
    // Cell 0 now holds more labels than the limit: old ones still count,
    // new ones are dropped.
    send_request(CMD_VOTE, 15'd0, 24'h000000, pick_gap(1'b0));
    send_request(CMD_VOTE, 15'd0, 24'h000001, pick_gap(1'b0));
    send_request(CMD_VOTE, 15'd0, 24'hFFFFFF, pick_gap(1'b0));

    // An all-ones limit acts as the full slot count.
    set_slot_limit('1);
    send_request(CMD_VOTE, 15'd1, 24'hABCDEF, pick_gap(1'b0));
    send_request(CMD_READ, 15'd1, 24'hFFFFFF, pick_gap(1'b0));

    // ---- Back-to-back burst: hammer one label in a fresh cell ----
    set_slot_limit(LIM_RESET);
    for (int n = 0; n < BURST_VOTES; n++)
      send_request(CMD_VOTE, 15'd2, 24'hC3A55A, 0);
    send_request(CMD_READ, 15'd2, 24'h000000, 0);

    // ---- Random part: phases of slot limits, mostly votes on a few hot cells ----
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       lim = SLOTS;
        1:       lim = (1 << CFG_W) - 1;
        2:       lim = $urandom_range(2, SLOTS - 1);
        3:       lim = 1;
        4:       lim = 0;
        default: lim = $urandom_range(SLOTS + 1, (1 << CFG_W) - 2);
      endcase
      set_slot_limit(CFG_W'(lim));
      // Swap in a few fresh cells so empty lists keep turning up.
      for (int k = 0; k < 3; k++)
        hot_cell[$urandom_range(0, HOT_CELLS-1)] = 15'($urandom_range(0, LAST_CELL));
      // Run two phases without any idle cycles.
      steady = (ph == 1 || ph == 4);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r  = $urandom_range(0, 99);
        cl = hot_cell[$urandom_range(0, HOT_CELLS-1)];
        // Skew toward the low pool entries so labels repeat and counts grow,
        // while the tail still fills lists to the limit and beyond.
        pick = $urandom_range(0, $urandom_range(3, POOL_LABELS-1));
        if (r < 70)
          send_request(CMD_VOTE, cl, label_pool[pick], pick_gap(steady));
        else if (r < 82)
          send_request(CMD_READ, cl, LABEL_W'($urandom()), pick_gap(steady));
        else if (r < 92)
          send_request(CMD_VOTE, 15'($urandom_range(0, LAST_CELL)),
                       LABEL_W'($urandom()), pick_gap(steady));
        else
          send_request(CMD_READ, 15'($urandom_range(0, LAST_CELL)),
                       LABEL_W'($urandom()), pick_gap(steady));
        // Now and then pause until every owed result is back.
        if (!steady && $urandom_range(0, 39) == 0) drain_results();
      end
    end

    // Wait out the last answers, then watch a while for stray strobes.
    drain_results();
    repeat (40) @(posedge clk);
    if (fault_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
rtl/lmv_pkg.sv
rtl/lmv_ram.sv
rtl/lmv_scan.sv
rtl/per_cell_label_mode_vote_unit.sv
sim/label_vote_checker.sv
sim/testbench.sv
